/* src/rrsg_pkg.sv */
// rrsg_pkg: shared types and constants of the rounded rectangle span generator
// no dependencies
package rrsg_pkg;
	localparam int MAX_RADIUS = 31;
	localparam int RW = 5;

	localparam logic [2:0] REG_CLIP_LEFT = 3'd0;
	localparam logic [2:0] REG_CLIP_TOP = 3'd1;
	localparam logic [2:0] REG_CLIP_RIGHT = 3'd2;
	localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
	localparam logic [2:0] REG_ORIGIN_X = 3'd4;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd5;
	localparam logic [2:0] REG_OPACITY_FLOOR = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE, ST_BODY, ST_SQRT, ST_TOP, ST_BOT, ST_DROP
	} state_t;

	typedef struct packed {
		logic load;
		logic sqrt_start;
		logic emit_drop;
		logic emit_body;
		logic emit_top;
		logic emit_bot;
		logic next_row;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic sqrt_done;
		logic last_row;
		logic out_free;
	} sts_t;
endpackage

/* src/rrsg_ctrl.sv */
// rrsg_ctrl: sequencer of drop, body band and corner row strips
// depends on rrsg_pkg
module rrsg_ctrl import rrsg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DROP;
				end
			end
			ST_DROP: begin
				if (sts.drop) begin
					if (sts.out_free) begin
						cmd.emit_drop = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_BODY;
				end
			end
			ST_BODY: begin
				if (sts.out_free) begin
					cmd.emit_body = 1'b1;
					cmd.sqrt_start = 1'b1;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sts.sqrt_done) state_d = ST_TOP;
			end
			ST_TOP: begin
				if (sts.out_free) begin
					cmd.emit_top = 1'b1;
					state_d = ST_BOT;
				end
			end
			ST_BOT: begin
				if (sts.out_free) begin
					cmd.emit_bot = 1'b1;
					if (sts.last_row) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_row = 1'b1;
						cmd.sqrt_start = 1'b1;
						state_d = ST_SQRT;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE) else $error("load outside idle");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_drop, cmd.emit_body, cmd.emit_top, cmd.emit_bot}))
		else $error("multiple emits");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_drop || cmd.emit_body || cmd.emit_top || cmd.emit_bot) |-> sts.out_free)
		else $error("emit into full output");
endmodule

/* src/rrsg_dp.sv */
// rrsg_dp: request registers, radius clamp, bit serial square root, clip and output
// depends on rrsg_pkg
module rrsg_dp import rrsg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic signed [15:0] rect_left,
	input  logic signed [15:0] rect_top,
	input  logic signed [15:0] rect_right,
	input  logic signed [15:0] rect_bottom,
	input  logic signed [15:0] corner_radius,
	input  logic        [7:0]  opacity,
	input  logic        [31:0] fill_color,
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [15:0] cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] strip_left,
	output logic signed [16:0] strip_top,
	output logic signed [16:0] strip_right,
	output logic signed [16:0] strip_bottom,
	output logic        [31:0] strip_color,
	output logic               strip_empty,
	output logic               last_strip
);
	logic signed [15:0] clip_l_q, clip_t_q, clip_r_q, clip_b_q, org_x_q, org_y_q;
	logic [7:0] opa_floor_q;
	logic signed [15:0] x1_q, y1_q, x2_q, y2_q, rad_q;
	logic [7:0] opa_q;
	logic [31:0] color_q;
	logic [RW-1:0] r_q, row_q;
	logic [RW-1:0] off_q;
	// square root
	logic [10:0] sq_n_q;
	logic [10:0] sq_res_q;
	logic [10:0] sq_bit_q;
	logic sq_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_l_q <= '0; clip_t_q <= '0;
			clip_r_q <= 16'sd32767; clip_b_q <= 16'sd32767;
			org_x_q <= '0; org_y_q <= '0;
			opa_floor_q <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLIP_LEFT: clip_l_q <= cfg_data;
				REG_CLIP_TOP: clip_t_q <= cfg_data;
				REG_CLIP_RIGHT: clip_r_q <= cfg_data;
				REG_CLIP_BOTTOM: clip_b_q <= cfg_data;
				REG_ORIGIN_X: org_x_q <= cfg_data;
				REG_ORIGIN_Y: org_y_q <= cfg_data;
				REG_OPACITY_FLOOR: opa_floor_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// radius clamp on the registered request
	logic signed [17:0] w, h, shorter, half;
	logic [RW-1:0] r_c;
	logic drop_c;
	always_comb begin
		w = 18'(x2_q) - 18'(x1_q) + 18'sd1;
		h = 18'(y2_q) - 18'(y1_q) + 18'sd1;
		shorter = (w < h) ? w : h;
		half = (shorter < 0) ? -((-shorter) >>> 1) : (shorter >>> 1);
		if (18'(rad_q) < half) half = 18'(rad_q);
		if (half > 18'(MAX_RADIUS)) half = 18'(MAX_RADIUS);
		r_c = (half > 0) ? half[RW-1:0] : '0;
		drop_c = (opa_q <= opa_floor_q) || (rad_q <= 0) || (half <= 0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q <= rect_left; y1_q <= rect_top; x2_q <= rect_right; y2_q <= rect_bottom;
			rad_q <= corner_radius; opa_q <= opacity; color_q <= fill_color;
		end
		r_q <= r_c;
		if (cmd.emit_body) row_q <= '0;
		else if (cmd.next_row) row_q <= row_q + 1'b1;
	end

	// floor sqrt of r*r - d*d, one bit pair per cycle
	logic [RW-1:0] d_c;
	logic [10:0] rr, dd;
	assign d_c = r_q - 1'b1 - (cmd.emit_body ? '0 : (row_q + 1'b1));
	assign rr = 11'(r_q) * 11'(r_q);
	assign dd = 11'(d_c) * 11'(d_c);

	logic [10:0] trial;
	assign trial = sq_res_q + sq_bit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
		end else if (cmd.sqrt_start) begin
			sq_busy_q <= 1'b1;
		end else if (sq_busy_q && sq_bit_q == '0) begin
			sq_busy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sq_n_q <= rr - dd;
			sq_res_q <= '0;
			sq_bit_q <= 11'd1024;
		end else if (sq_busy_q && sq_bit_q != '0) begin
			if (sq_n_q >= trial) begin
				sq_n_q <= sq_n_q - trial;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (sq_busy_q && sq_bit_q == '0) off_q <= r_q - sq_res_q[RW-1:0];
	end

	assign sts.drop = drop_c;
	assign sts.sqrt_done = sq_busy_q && sq_bit_q == '0;
	assign sts.last_row = (row_q == r_q - 1'b1);
	assign sts.out_free = !out_valid || out_ready;

	// strip geometry and clip
	logic signed [17:0] sx1, sy1, sx2, sy2, a, b, c, dy;
	logic ok;
	always_comb begin
		sx1 = 18'(x1_q); sx2 = 18'(x2_q);
		sy1 = 18'(y1_q); sy2 = 18'(y2_q);
		ok = 1'b1;
		if (cmd.emit_body) begin
			sy1 = 18'(y1_q) + 18'(r_q);
			sy2 = 18'(y2_q) - 18'(r_q);
			ok = sy2 >= sy1;
		end else begin
			sx1 = 18'(x1_q) + 18'(off_q);
			sx2 = 18'(x2_q) - 18'(off_q);
			ok = sx2 >= sx1;
			if (cmd.emit_top) begin
				sy1 = 18'(y1_q) + 18'(row_q); sy2 = sy1;
			end else begin
				sy1 = 18'(y2_q) - 18'(row_q); sy2 = sy1;
			end
		end
		a = (sx1 > 18'(clip_l_q)) ? sx1 : 18'(clip_l_q);
		b = (sy1 > 18'(clip_t_q)) ? sy1 : 18'(clip_t_q);
		c = (sx2 < 18'(clip_r_q)) ? sx2 : 18'(clip_r_q);
		dy = (sy2 < 18'(clip_b_q)) ? sy2 : 18'(clip_b_q);
		if (cmd.emit_drop || a > c || b > dy) ok = 1'b0;
	end

	logic emit;
	assign emit = cmd.emit_drop | cmd.emit_body | cmd.emit_top | cmd.emit_bot;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (emit) begin
			strip_empty <= !ok;
			last_strip <= cmd.emit_drop || (cmd.emit_bot && sts.last_row);
			strip_left <= ok ? 17'(a - 18'(org_x_q)) : '0;
			strip_top <= ok ? 17'(b - 18'(org_y_q)) : '0;
			strip_right <= ok ? 17'(c - 18'(org_x_q)) : '0;
			strip_bottom <= ok ? 17'(dy - 18'(org_y_q)) : '0;
			strip_color <= ok ? color_q : '0;
		end
	end
endmodule

/* src/rounded_rect_span_generator_core.sv */
// channel   direction  handshake
// request   in         in_valid / in_ready
// strip     out        out_valid / out_ready
// config    in         cfg_we, no handshake
// a request is accepted in idle and checked for a drop, then the body band is emitted
// each corner row runs the bit serial square root, then emits a top and a bottom strip
// a dropped request emits one empty last strip; out_ready low stalls the sequencer
// reset sets the state, out_valid, the square root busy flag and the config registers to defaults
// depends on rrsg_pkg, rrsg_ctrl, rrsg_dp
module rounded_rect_span_generator_core import rrsg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] rect_left,
	input  logic signed [15:0] rect_top,
	input  logic signed [15:0] rect_right,
	input  logic signed [15:0] rect_bottom,
	input  logic signed [15:0] corner_radius,
	input  logic        [7:0]  opacity,
	input  logic        [31:0] fill_color,
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [15:0] cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] strip_left,
	output logic signed [16:0] strip_top,
	output logic signed [16:0] strip_right,
	output logic signed [16:0] strip_bottom,
	output logic        [31:0] strip_color,
	output logic               strip_empty,
	output logic               last_strip
);
	cmd_t cmd;
	sts_t sts;

	rrsg_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .sts, .cmd);

	rrsg_dp u_dp (
		.clk, .arst_n, .cmd, .sts,
		.rect_left, .rect_top, .rect_right, .rect_bottom, .corner_radius,
		.opacity, .fill_color, .cfg_we, .cfg_index, .cfg_data,
		.out_valid, .out_ready, .strip_left, .strip_top, .strip_right,
		.strip_bottom, .strip_color, .strip_empty, .last_strip
	);
endmodule
